// ----- design/rwfr_pkg.sv -----
// shared constants, codes and types of the register write frame receiver
package rwfr_pkg;

    localparam int REG_COUNT  = 256;
    localparam int REG_ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    // limit held one bit wider than an address so that a full 64k store still compares
    localparam logic [16:0] REG_LIMIT = 17'(REG_COUNT);

    localparam logic [7:0] FRAME_HEADER = 8'h55;
    // last byte of a frame sits at this position
    localparam logic [2:0] FRAME_LAST_POS = 3'd5;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_WRITTEN = 2'd1,
        ST_BAD     = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        logic                  en;
        logic [REG_ADDR_W-1:0] addr;
        logic [15:0]           data;
    } t_wr_req;

endpackage

// ----- design/rwfr_if.sv -----
// valid/ready channel interfaces for requests and results
interface rwfr_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  rx_byte;
    logic [15:0] read_addr;

    modport source (output valid, output op, output rx_byte, output read_addr, input ready);
    modport sink   (input valid, input op, input rx_byte, input read_addr, output ready);
endinterface

interface rwfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [15:0] read_data;

    modport source (output valid, output frame_status, output read_data, input ready);
    modport sink   (input valid, input frame_status, input read_data, output ready);
endinterface

// ----- design/rwfr_frame.sv -----
// frame assembly, header and checksum check, address range check, write request generation
module rwfr_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic                i_op,
    input  logic [7:0]          i_rx_byte,
    output rwfr_pkg::t_wr_req   o_wr,
    output rwfr_pkg::t_status   o_status
);

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [7:0] r_bytes [5];
    logic [7:0] w_sum;
    logic [15:0] w_addr;
    logic       w_end;
    logic       w_good;
    logic       w_in_range;

    // positions five and above close the frame
    assign w_end      = !i_op && (r_pos >= rwfr_pkg::FRAME_LAST_POS);
    assign w_sum      = r_bytes[0] + r_bytes[1] + r_bytes[2] + r_bytes[3] + r_bytes[4];
    assign w_good     = (r_bytes[0] == rwfr_pkg::FRAME_HEADER) && (w_sum == i_rx_byte);
    assign w_addr     = {r_bytes[1], r_bytes[2]};
    assign w_in_range = {1'b0, w_addr} < rwfr_pkg::REG_LIMIT;

    always_comb begin
        o_status = rwfr_pkg::ST_NONE;
        if (w_end) begin
            if (!w_good) begin
                o_status = rwfr_pkg::ST_BAD;
            end else if (!w_in_range) begin
                o_status = rwfr_pkg::ST_RANGE;
            end else begin
                o_status = rwfr_pkg::ST_WRITTEN;
            end
        end
    end

    assign o_wr.en   = i_advance && w_end && w_good && w_in_range;
    assign o_wr.addr = w_addr[rwfr_pkg::REG_ADDR_W-1:0];
    assign o_wr.data = {r_bytes[3], r_bytes[4]};

    always_comb begin
        n_pos = r_pos;
        if (!i_op) begin
            n_pos = w_end ? 3'd0 : r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

    // byte slots are always filled before the frame end reads them
    always_ff @(posedge i_clk) begin
        if (i_advance && !i_op && !w_end) begin
            r_bytes[r_pos] <= i_rx_byte;
        end
    end

endmodule

// ----- design/rwfr_regs.sv -----
// register store with per-entry valid bits and registered read
module rwfr_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwfr_pkg::t_wr_req i_wr,
    input  logic              i_advance,
    input  logic              i_rd_req,
    input  logic [15:0]       i_rd_addr,
    output logic [15:0]       o_rd_data
);

    logic [15:0]                    r_mem [rwfr_pkg::REG_COUNT];
    logic [rwfr_pkg::REG_COUNT-1:0] r_valid;
    logic [15:0]                    r_rd_data;
    logic                           r_rd_hit;
    logic [rwfr_pkg::REG_ADDR_W-1:0] w_rd_idx;
    logic                           w_rd_in_range;

    assign w_rd_idx      = i_rd_addr[rwfr_pkg::REG_ADDR_W-1:0];
    assign w_rd_in_range = {1'b0, i_rd_addr} < rwfr_pkg::REG_LIMIT;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_advance) begin
            r_rd_data <= r_mem[w_rd_idx];
        end
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_advance) begin
                r_rd_hit <= i_rd_req && w_rd_in_range && r_valid[w_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 16'd0;

endmodule

// ----- design/register_write_frame_receiver_top.sv -----
// top level of the checksummed register write frame receiver
//
//  channel  dir  payload                         notes
//  i_req    in   op, rx_byte, read_addr          one request per byte or read
//  o_rsp    out  frame_status, read_data         exactly one result per request
//
// a request is registered on acceptance and then processed into the output register;
// one request per cycle is taken while the output is not stalled
// reset is synchronous and active low; it empties both stages, restarts frame
// counting and marks every store entry unwritten so it reads back as zero
// a stalled output holds the processing stage, and the input stage still takes
// a request while its slot is free or moving on
module register_write_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rwfr_in_if.sink     i_req,
    rwfr_out_if.source  o_rsp
);

    // input stage
    logic        r_in_valid;
    logic        r_op;
    logic [7:0]  r_rx_byte;
    logic [15:0] r_read_addr;

    // output stage
    logic              r_out_valid;
    rwfr_pkg::t_status r_status;

    logic              w_advance;
    rwfr_pkg::t_wr_req w_wr;
    rwfr_pkg::t_status w_status;
    logic [15:0]       w_rd_data;

    // the processing stage moves when the result slot is free or being drained
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op        <= i_req.op;
            r_rx_byte   <= i_req.rx_byte;
            r_read_addr <= i_req.read_addr;
        end
    end

    // frame assembly and checks
    rwfr_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_op      (r_op),
        .i_rx_byte (r_rx_byte),
        .o_wr      (w_wr),
        .o_status  (w_status)
    );

    // register store, read data registered alongside the status
    rwfr_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_advance (w_advance),
        .i_rd_req  (r_op),
        .i_rd_addr (r_read_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_status    <= rwfr_pkg::ST_NONE;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_status    <= w_status;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.frame_status = r_status;
    assign o_rsp.read_data    = w_rd_data;

`ifndef ASSERT_OFF
    // store writes only come from a byte request that is moving on
    a_wr_only_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (w_advance && !r_op))
        else $error("store write outside a byte request");

    // a read request never reports a frame end
    a_read_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_op) |=> (r_status == rwfr_pkg::ST_NONE))
        else $error("read request reported a frame status");

    // a written status matches a store write in the same step
    a_written_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> ((r_status == rwfr_pkg::ST_WRITTEN) == $past(w_wr.en)))
        else $error("written status and store write disagree");

    // a byte request never returns read data
    a_byte_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_op) |=> (o_rsp.read_data == 16'd0))
        else $error("byte request returned read data");
`endif

endmodule

// ----- bench/register_write_frame_receiver_top_test.sv -----
// self-checking testbench for the frame receiver: directed table, then random frames
module register_write_frame_receiver_top_test;

    // request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_PCT     = 38;
    // margin past the two stages for the last result
    localparam int DRAIN_CYCLES = 8;
    // worst case is far below this even with long random gaps on both sides
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIRECTED_ROWS = 27;

    typedef struct packed {
        logic        op;
        logic [7:0]  rx_byte;
        logic [15:0] read_addr;
    } t_request;

    typedef struct packed {
        rwfr_pkg::t_status status;
        logic [15:0]       data;
    } t_result;

    // known marks a row whose result is typed in here instead of predicted
    typedef struct packed {
        t_request req;
        logic     known;
        t_result  res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    rwfr_in_if  req_if ();
    rwfr_out_if rsp_if ();

    register_write_frame_receiver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // mirror of the frame assembler and the register store
    logic [2:0]  frame_pos;
    logic [7:0]  frame_buf  [0:4];
    logic [15:0] reg_mirror [0:rwfr_pkg::REG_COUNT-1];

    t_result expected_results [$];
    t_result oldest_result;
    int      mismatches;
    int      requests_sent;
    int      cycle_count;
    // set during the stretch where neither side idles
    bit      steady;

    // directed table: empty store reads, a good frame with a read in its middle,
    // bad header, bad checksum and an out-of-range write to the top of the address space
    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{'{OP_READ, 8'h00, 16'h0000}, 1'b1, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h55, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_READ, 8'hff, 16'hffff}, 1'b1, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'hff, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'hff, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'hff, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h52, 16'h0000}, 1'b1, '{rwfr_pkg::ST_WRITTEN, 16'h0000}},
        '{'{OP_READ, 8'h00, 16'h00ff}, 1'b1, '{rwfr_pkg::ST_NONE,    16'hffff}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b1, '{rwfr_pkg::ST_BAD,     16'h0000}},
        '{'{OP_BYTE, 8'h55, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b1, '{rwfr_pkg::ST_BAD,     16'h0000}},
        '{'{OP_BYTE, 8'h55, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'hff, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'hff, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h00, 16'h0000}, 1'b0, '{rwfr_pkg::ST_NONE,    16'h0000}},
        '{'{OP_BYTE, 8'h53, 16'h0000}, 1'b1, '{rwfr_pkg::ST_RANGE,   16'h0000}}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one request through the frame receiver: a byte joins the frame or ends it,
    // a read looks up the store; frame state is untouched by reads
    function automatic t_result predict_result(t_request req);
        t_result     res;
        logic [7:0]  sum;
        logic [15:0] wr_addr;
        res.status = rwfr_pkg::ST_NONE;
        res.data   = 16'h0000;
        if (req.op == OP_READ) begin
            if ({1'b0, req.read_addr} < rwfr_pkg::REG_LIMIT) begin
                res.data = reg_mirror[req.read_addr[rwfr_pkg::REG_ADDR_W-1:0]];
            end
        end else if (frame_pos < rwfr_pkg::FRAME_LAST_POS) begin
            frame_buf[frame_pos] = req.rx_byte;
            frame_pos = frame_pos + 3'd1;
        end else begin
            // sixth byte: header checked first, then the checksum, then the address
            sum = frame_buf[0] + frame_buf[1] + frame_buf[2] + frame_buf[3] + frame_buf[4];
            wr_addr = {frame_buf[1], frame_buf[2]};
            frame_pos = 3'd0;
            if (frame_buf[0] != rwfr_pkg::FRAME_HEADER || sum != req.rx_byte) begin
                res.status = rwfr_pkg::ST_BAD;
            end else if ({1'b0, wr_addr} >= rwfr_pkg::REG_LIMIT) begin
                res.status = rwfr_pkg::ST_RANGE;
            end else begin
                reg_mirror[wr_addr[rwfr_pkg::REG_ADDR_W-1:0]] = {frame_buf[3], frame_buf[4]};
                res.status = rwfr_pkg::ST_WRITTEN;
            end
        end
        return res;
    endfunction

    // present one request from a falling edge, hold it until accepted, and
    // queue its result; a typed-in result overrides the prediction
    task automatic send_request(t_request req, logic known, t_result known_res);
        t_result predicted;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= req.op;
        req_if.rx_byte   <= req.rx_byte;
        req_if.read_addr <= req.read_addr;
        forever begin
            @(posedge i_clk);
            if (req_if.ready) break;
        end
        predicted = predict_result(req);
        expected_results.push_back(known ? known_res : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] rx);
        send_request('{OP_BYTE, rx, 16'($urandom)}, 1'b0, '{rwfr_pkg::ST_NONE, 16'h0000});
    endtask

    // reads mostly land on the low addresses that writes favor
    task automatic send_read();
        logic [15:0] addr;
        case ($urandom_range(0, 9))
            0, 1, 2: addr = 16'($urandom);
            3, 4, 5: addr = 16'($urandom_range(0, 15));
            default: addr = 16'($urandom_range(0, rwfr_pkg::REG_COUNT - 1));
        endcase
        send_request('{OP_READ, 8'($urandom), addr}, 1'b0, '{rwfr_pkg::ST_NONE, 16'h0000});
    endtask

    // one six-byte frame of random content and a random kind, with reads
    // scattered between its bytes
    task automatic send_frame();
        logic [7:0]  fb [0:5];
        logic [15:0] addr;
        int          kind;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            addr = ($urandom_range(0, 1) == 0)
                 ? 16'($urandom_range(0, 15))
                 : 16'($urandom_range(0, rwfr_pkg::REG_COUNT - 1));
        end else begin
            addr = 16'($urandom_range(rwfr_pkg::REG_COUNT, 65535));
        end
        fb[0] = rwfr_pkg::FRAME_HEADER;
        fb[1] = addr[15:8];
        fb[2] = addr[7:0];
        fb[3] = 8'($urandom);
        fb[4] = 8'($urandom);
        fb[5] = fb[0] + fb[1] + fb[2] + fb[3] + fb[4];
        if (kind >= 92) begin
            // pure noise
            for (int i = 0; i < 6; i++) fb[i] = 8'($urandom);
        end else if (kind >= 80) begin
            // broken checksum
            fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
        end else if (kind >= 70) begin
            // broken header, checksum recomputed so only the header fails
            fb[0] = rwfr_pkg::FRAME_HEADER ^ 8'($urandom_range(1, 255));
            fb[5] = fb[0] + fb[1] + fb[2] + fb[3] + fb[4];
        end
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 99) < 15) send_read();
            send_byte(fb[i]);
        end
    endtask

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d data %h",
                         $time, rsp_if.frame_status, rsp_if.read_data);
                mismatches++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (rsp_if.frame_status != oldest_result.status) begin
                    $display("%0t: frame_status: expected %0d, actual %0d",
                             $time, oldest_result.status, rsp_if.frame_status);
                    mismatches++;
                end
                if (rsp_if.read_data != oldest_result.data) begin
                    $display("%0t: read_data: expected %h, actual %h",
                             $time, oldest_result.data, rsp_if.read_data);
                    mismatches++;
                end
            end
        end
    end

    // result side backpressure
    always @(negedge i_clk) begin
        rsp_if.ready <= i_rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        cycle_count      = 0;
        mismatches       = 0;
        requests_sent    = 0;
        steady           = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.op        = OP_BYTE;
        req_if.rx_byte   = 8'h00;
        req_if.read_addr = 16'h0000;
        rsp_if.ready     = 1'b0;
        frame_pos        = 3'd0;
        for (int i = 0; i < 5; i++) frame_buf[i] = 8'h00;
        for (int i = 0; i < rwfr_pkg::REG_COUNT; i++) reg_mirror[i] = 16'h0000;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(directed_rows[r].req, directed_rows[r].known, directed_rows[r].res);
        end

        // whole frames keep the byte count aligned, so most frames reach the store
        while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            steady = (requests_sent >= 700 && requests_sent < 1000);
            send_frame();
        end
        steady = 1'b0;
        req_if.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/rwfr_pkg.sv
design/rwfr_if.sv
design/rwfr_frame.sv
design/rwfr_regs.sv
design/register_write_frame_receiver_top.sv
bench/register_write_frame_receiver_top_test.sv
